// ===== rtl/url_span_scanner_defines.svh =====
// Assertion macros shared by the scanner RTL.
`ifndef URL_SPAN_SCANNER_DEFINES_SVH
`define URL_SPAN_SCANNER_DEFINES_SVH

// Checked on every rising clock edge, muted while reset is asserted.
`define USS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, also during reset.
`define USS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/uss_pkg.sv =====
package uss_pkg;

  localparam int unsigned PosBitsDefault = 16;
  localparam int unsigned FieldW         = 16;
  localparam int unsigned ByteW          = 8;

  localparam logic [ByteW-1:0] ChH     = 8'h68;  // 'h'
  localparam logic [ByteW-1:0] ChT     = 8'h74;  // 't'
  localparam logic [ByteW-1:0] ChP     = 8'h70;  // 'p'
  localparam logic [ByteW-1:0] ChS     = 8'h73;  // 's'
  localparam logic [ByteW-1:0] ChA     = 8'h61;  // 'a'
  localparam logic [ByteW-1:0] ChR     = 8'h72;  // 'r'
  localparam logic [ByteW-1:0] ChE     = 8'h65;  // 'e'
  localparam logic [ByteW-1:0] ChF     = 8'h66;  // 'f'
  localparam logic [ByteW-1:0] ChLt    = 8'h3C;  // '<'
  localparam logic [ByteW-1:0] ChGt    = 8'h3E;  // '>'
  localparam logic [ByteW-1:0] ChColon = 8'h3A;  // ':'
  localparam logic [ByteW-1:0] ChSlash = 8'h2F;  // '/'
  localparam logic [ByteW-1:0] ChEq    = 8'h3D;  // '='
  localparam logic [ByteW-1:0] ChQuote = 8'h22;  // '"'
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;

  // Register index of scan_mode in the config map.
  localparam logic RegScanMode = 1'b0;

  typedef struct packed {
    logic [FieldW-1:0] url_start;
    logic [FieldW-1:0] url_end;
    logic              offsets_saturated;
  } uss_result_t;

  function automatic logic [ByteW-1:0] to_lower(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [ByteW-1:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

endpackage

// ===== rtl/uss_in_if.sv =====
interface uss_in_if
  import uss_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_value;
  logic             last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

// ===== rtl/uss_out_if.sv =====
interface uss_out_if
  import uss_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FieldW-1:0] url_start;
  logic [FieldW-1:0] url_end;
  logic              offsets_saturated;

  modport source (output valid, output url_start, output url_end,
                  output offsets_saturated, input ready);
  modport sink   (input valid, input url_start, input url_end,
                  input offsets_saturated, output ready);
endinterface

// ===== rtl/url_span_scanner.sv =====
// URL span scanner.
// in_i carries one text byte per beat (byte_value, last_byte marks the final
// byte of a block). out_o carries one beat per URL that ends: url_start,
// url_end (one past the last character) and offsets_saturated.
// scan_mode is written over the APB port at address 0: 0 finds plain http(s):// URLs, 1 only href
// values of <a> tags. The user must write it only while the block is idle; the block does not check it.
// Throughput: one byte per cycle while the skid entry is free. The per-byte
// recognizer step and the offset counter update are combinational logic
// after the state registers. A result for the byte beat that ends the URL is
// registered into the output register, or into the skid entry when that is full.
// The output register is backed by a one-entry skid register, so bytes keep
// flowing while a result waits; in_i.ready drops only while the skid entry
// is occupied, i.e. after two results are pending under a stalled receiver.
// Offsets count up to 2^POS_BITS-1 and stick there; results then carry
// offsets_saturated. A last_byte beat returns scanner state and offsets to
// zero; scan_mode is kept.
// Reset (rst_ni low) clears the scanner, the result queue and scan_mode.
module url_span_scanner
  import uss_pkg::*;
#(
  parameter int unsigned POS_BITS = PosBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  uss_in_if.sink      in_i,
  uss_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "url_span_scanner_defines.svh"

  localparam logic [POS_BITS-1:0] PosMax = '1;

  typedef enum logic [4:0] {
    S_INIT   = 5'd0,
    S_H      = 5'd1,
    S_HT     = 5'd2,
    S_HTT    = 5'd3,
    S_HTTP   = 5'd4,
    S_HTTPS  = 5'd5,
    S_COLON  = 5'd6,
    S_SLASH  = 5'd7,
    S_URL    = 5'd8,
    S_LT     = 5'd9,
    S_TAG    = 5'd10,
    S_TAG_H  = 5'd11,
    S_TAG_R  = 5'd12,
    S_TAG_E  = 5'd13,
    S_EQ     = 5'd14,
    S_QUOTE  = 5'd15,
    S_HSTART = 5'd16
  } scan_state_e;

  scan_state_e       scan_state_q, scan_state_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] start_q, start_d;
  logic [1:0]        cont_q, cont_d;
  logic              sat_q, sat_d;
  logic              scan_mode_q;

  logic              out_valid_q, skid_valid_q;
  uss_result_t       out_data_q, skid_data_q;
  uss_result_t       res;
  logic              res_valid;
  logic              in_fire, out_pop, cfg_wr;

  // Recognizer step signals
  scan_state_e       rec_state;
  logic [POS_BITS-1:0] rec_start;
  logic              rec_end;
  logic [ByteW-1:0]  ch, lc;
  logic              do_rec;

  assign in_fire = in_i.valid && in_i.ready;
  assign out_pop = out_valid_q && out_o.ready;
  assign in_i.ready = !skid_valid_q;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegScanMode) ? {31'b0, scan_mode_q} : 32'b0;

  // Lead bytes are seen as NUL.
  assign ch = in_i.byte_value[7] ? '0 : in_i.byte_value;
  assign lc = to_lower(ch);
  assign do_rec = (cont_q == 2'd0) &&
                  (!in_i.byte_value[7] ||
                   (in_i.byte_value >= 8'hC0 && in_i.byte_value <= 8'hF7));

  always_comb begin
    rec_state = scan_state_q;
    rec_start = start_q;
    rec_end   = 1'b0;
    unique case (scan_state_q)
      S_INIT: begin
        if (!scan_mode_q) begin
          if (lc == ChH) begin
            rec_state = S_H;
            rec_start = pos_q;
          end
        end else if (ch == ChLt) begin
          rec_state = S_LT;
        end
      end
      S_H:     rec_state = (lc == ChT) ? S_HT : S_INIT;
      S_HT:    rec_state = (lc == ChT) ? S_HTT : S_INIT;
      S_HTT:   rec_state = (lc == ChP) ? S_HTTP : S_INIT;
      S_HTTP: begin
        if (lc == ChS) rec_state = S_HTTPS;
        else           rec_state = (ch == ChColon) ? S_COLON : S_INIT;
      end
      S_HTTPS: rec_state = (ch == ChColon) ? S_COLON : S_INIT;
      S_COLON: rec_state = (ch == ChSlash) ? S_SLASH : S_INIT;
      S_SLASH: rec_state = (ch == ChSlash) ? S_URL : S_INIT;
      S_URL: begin
        if (is_space(ch) || ch == ChQuote || ch == ChGt) begin
          rec_state = S_INIT;
          rec_end   = 1'b1;
        end
      end
      S_LT:    rec_state = (lc == ChA) ? S_TAG : S_INIT;
      S_TAG:   rec_state = (lc == ChH) ? S_TAG_H : (lc == ChGt) ? S_INIT : S_TAG;
      S_TAG_H: rec_state = (lc == ChR) ? S_TAG_R : (lc == ChGt) ? S_INIT : S_TAG;
      S_TAG_R: rec_state = (lc == ChE) ? S_TAG_E : (lc == ChGt) ? S_INIT : S_TAG;
      S_TAG_E: rec_state = (lc == ChF) ? S_EQ : (lc == ChGt) ? S_INIT : S_TAG;
      S_EQ:    rec_state = (ch == ChEq) ? S_QUOTE : S_INIT;
      S_QUOTE, S_HSTART: begin
        if (scan_state_q == S_QUOTE && ch == ChQuote) begin
          rec_state = S_HSTART;
        end else if (lc == ChH) begin
          rec_state = S_H;
          rec_start = pos_q;
        end else begin
          rec_state = S_INIT;
        end
      end
      default: rec_state = S_INIT;
    endcase
  end

  always_comb begin
    logic stray_end;
    logic last_end;
    logic clamped;
    scan_state_d = scan_state_q;
    start_d      = start_q;
    cont_d       = cont_q;
    sat_d        = sat_q;
    pos_d        = pos_q;
    stray_end    = 1'b0;
    clamped      = 1'b0;

    if (cont_q != 2'd0) begin
      cont_d = cont_q - 2'd1;
    end else if (do_rec) begin
      scan_state_d = rec_state;
      start_d      = rec_start;
      if (in_i.byte_value[7]) begin
        cont_d = (in_i.byte_value <= 8'hDF) ? 2'd1 :
                 (in_i.byte_value <= 8'hEF) ? 2'd2 : 2'd3;
      end
    end else begin
      stray_end    = (scan_state_q == S_URL);
      scan_state_d = S_INIT;
    end

    last_end = in_i.last_byte && (scan_state_d == S_URL) && !(do_rec && rec_end)
               && !stray_end;
    res_valid = in_fire && ((do_rec && rec_end) || stray_end || last_end);

    res.url_start = FieldW'(start_q);
    res.url_end   = FieldW'(pos_q);
    if (last_end) begin
      clamped = (pos_q == PosMax);
      res.url_end = clamped ? FieldW'(PosMax) : FieldW'(pos_q + 1'b1);
    end
    res.offsets_saturated = sat_q || clamped;

    if (in_i.last_byte) begin
      scan_state_d = S_INIT;
      pos_d        = '0;
      start_d      = '0;
      cont_d       = 2'd0;
      sat_d        = 1'b0;
    end else if (pos_q == PosMax) begin
      sat_d = 1'b1;
    end else begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_state_q <= S_INIT;
      pos_q        <= '0;
      start_q      <= '0;
      cont_q       <= 2'd0;
      sat_q        <= 1'b0;
    end else if (in_fire) begin
      scan_state_q <= scan_state_d;
      pos_q        <= pos_d;
      start_q      <= start_d;
      cont_q       <= cont_d;
      sat_q        <= sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode_q <= 1'b0;
    end else if (cfg_wr && paddr[2] == RegScanMode) begin
      scan_mode_q <= pwdata[0];
    end
  end

  // Output register plus one skid entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (out_pop || !out_valid_q) begin
      out_valid_q <= res_valid;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_data_q <= skid_data_q;
      end
    end else if (out_pop || !out_valid_q) begin
      if (res_valid) begin
        out_data_q <= res;
      end
    end else if (res_valid) begin
      skid_data_q <= res;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.url_start         = out_data_q.url_start;
  assign out_o.url_end           = out_data_q.url_end;
  assign out_o.offsets_saturated = out_data_q.offsets_saturated;

  `USS_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid entry without output entry")
  `USS_ASSERT(a_sat_at_ceiling, sat_q |-> (pos_q == PosMax), "saturated below ceiling")
  `USS_ASSERT(a_last_clears, (in_fire && in_i.last_byte) |=> (pos_q == '0 && scan_state_q == S_INIT && cont_q == 2'd0 && !sat_q), "block end did not clear state")
  `USS_ASSERT(a_skip_holds_state, (in_fire && cont_q != 2'd0 && !in_i.last_byte) |=> $stable(scan_state_q), "continuation byte moved the recognizer")

endmodule
